// File: design/spmq_pkg.sv
package spmq_pkg;

	localparam int unsigned OP_W       = 2;
	localparam int unsigned PRIO_W     = 8;
	localparam int unsigned TAG_IO_W   = 16;
	localparam int unsigned STATUS_W   = 2;
	localparam int unsigned OCC_W      = 5;

	localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
	localparam logic [OP_W-1:0] OP_READ  = 2'd1;
	localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

	typedef struct packed {
		logic [OP_W-1:0]     op;
		logic                ordered;
		logic [PRIO_W-1:0]   priority_req;
		logic [TAG_IO_W-1:0] tag;
	} req_word_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [TAG_IO_W-1:0] head_tag;
		logic [PRIO_W-1:0]   head_priority;
		logic [OCC_W-1:0]    occupancy;
	} rsp_word_t;

	// Per-cell update select; load has priority over the two shifts.
	typedef struct packed {
		logic load;
		logic from_left;
		logic from_right;
	} cell_ctl_t;

endpackage

// File: design/stable_priority_message_queue_unit.sv
// Stable priority message queue.
// Request channel (req_valid, req_stall, req_word) carries one command word:
// write, read-and-remove-head, or clear. Response channel (rsp_valid,
// rsp_stall, rsp_word) returns exactly one word per command with status,
// the removed head entry on a read, and the occupancy after the command.
// Entries live in a row of cells kept in service order. An ordered write
// compares its priority against every held cell at once, finds the first
// strictly greater one and shifts the tail right by one cell; an unordered
// write goes to the tail, and a read shifts every cell left. A command is
// captured in an input register and executed once the output register can
// take a word; its response then lands in the output register and rsp_valid
// rises. One command is accepted per cycle while the receiver does not stall;
// the cell row and count update in the same cycle the response is written.
// When the receiver stalls, the response register holds its word; an empty
// input register still takes one more command, after which req_stall rises.
// Reset empties the queue; cell contents are not cleared and are never read
// before being written.
module stable_priority_message_queue_unit import spmq_pkg::*; #(
	parameter int unsigned QUEUE_DEPTH = 16,
	parameter int unsigned TAG_WIDTH   = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_stall,
	input  req_word_t req_word,
	output logic      rsp_valid,
	input  logic      rsp_stall,
	output rsp_word_t rsp_word
);

	localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(QUEUE_DEPTH);

	req_word_t        req_s1;
	logic             valid_s1;
	rsp_word_t        rsp_q;
	rsp_word_t        rsp_next;
	logic             rsp_valid_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] count_next;

	logic advance;
	logic exec;
	logic full;
	logic empty;
	logic do_wr;
	logic do_rd;

	logic [TAG_WIDTH-1:0] new_tag;

	logic [PRIO_W-1:0]    cell_prio [QUEUE_DEPTH];
	logic [TAG_WIDTH-1:0] cell_tag  [QUEUE_DEPTH];
	logic [QUEUE_DEPTH-1:0] greater;
	logic [QUEUE_DEPTH-1:0] hit;
	logic [QUEUE_DEPTH-1:0] seen;
	logic                   any_hit;
	cell_ctl_t              ctl [QUEUE_DEPTH];

	assign advance   = !rsp_valid_q || !rsp_stall;
	assign req_stall = valid_s1 && !advance;
	assign exec      = valid_s1 && advance;
	assign full      = count_q == CNT_MAX;
	assign empty     = count_q == '0;
	assign do_wr     = exec && (req_s1.op == OP_WRITE) && !full;
	assign do_rd     = exec && (req_s1.op == OP_READ) && !empty;
	assign new_tag   = TAG_WIDTH'(req_s1.tag);

	// First held entry with a strictly greater priority marks the insert point.
	always_comb begin
		for (int i = 0; i < QUEUE_DEPTH; i++) begin
			hit[i] = req_s1.ordered && (CNT_W'(i) < count_q) && greater[i];
		end
		seen[0] = hit[0];
		for (int i = 1; i < QUEUE_DEPTH; i++) begin
			seen[i] = seen[i-1] || hit[i];
		end
		any_hit = seen[QUEUE_DEPTH-1];
	end

	always_comb begin
		for (int i = 0; i < QUEUE_DEPTH; i++) begin
			ctl[i].load       = do_wr && ((hit[i] && ((i == 0) || !seen[(i == 0) ? 0 : i-1]))
			                    || (!any_hit && (CNT_W'(i) == count_q)));
			ctl[i].from_left  = do_wr && (i != 0) && seen[(i == 0) ? 0 : i-1];
			ctl[i].from_right = do_rd && (i != QUEUE_DEPTH - 1);
		end
	end

	for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
		localparam int unsigned L = (g == 0) ? 0 : g - 1;
		localparam int unsigned R = (g == QUEUE_DEPTH - 1) ? g : g + 1;

		spmq_cell #(
			.TAG_WIDTH(TAG_WIDTH)
		) u_cell (
			.clk       (clk),
			.ctl       (ctl[g]),
			.new_prio  (req_s1.priority_req),
			.new_tag   (new_tag),
			.left_prio (cell_prio[L]),
			.left_tag  (cell_tag[L]),
			.right_prio(cell_prio[R]),
			.right_tag (cell_tag[R]),
			.greater   (greater[g]),
			.prio      (cell_prio[g]),
			.tag       (cell_tag[g])
		);
	end

	always_comb begin
		count_next = count_q;
		if (exec) begin
			unique case (req_s1.op)
				OP_WRITE: if (!full)  count_next = count_q + 1'b1;
				OP_READ:  if (!empty) count_next = count_q - 1'b1;
				OP_CLEAR: count_next = '0;
				default:  count_next = count_q;
			endcase
		end
	end

	always_comb begin
		rsp_next           = '0;
		rsp_next.status    = ST_OK;
		rsp_next.occupancy = OCC_W'(count_next);
		if (req_s1.op == OP_WRITE && full) begin
			rsp_next.status = ST_FULL;
		end
		if (req_s1.op == OP_READ) begin
			if (empty) begin
				rsp_next.status = ST_EMPTY;
			end else begin
				rsp_next.head_tag      = TAG_IO_W'(cell_tag[0]);
				rsp_next.head_priority = cell_prio[0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			rsp_valid_q <= 1'b0;
			count_q     <= '0;
		end else begin
			if (!req_stall) begin
				valid_s1 <= req_valid;
			end
			if (advance) begin
				rsp_valid_q <= valid_s1;
			end
			count_q <= count_next;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && !req_stall) begin
			req_s1 <= req_word;
		end
		if (exec) begin
			rsp_q <= rsp_next;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_word  = rsp_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_MAX)
		else $error("entry count above queue depth");

	a_full_occ: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_word.status == ST_FULL |-> rsp_word.occupancy == OCC_W'(QUEUE_DEPTH))
		else $error("dropped write reported with queue not full");

	a_empty_occ: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_word.status == ST_EMPTY |-> rsp_word.occupancy == '0)
		else $error("empty read reported with entries held");

	a_pop_count: assert property (@(posedge clk) disable iff (!arst_n)
		do_rd |=> count_q == $past(count_q) - 1'b1)
		else $error("read did not remove exactly one entry");

endmodule

// File: design/spmq_cell.sv
module spmq_cell import spmq_pkg::*; #(
	parameter int unsigned TAG_WIDTH = 16
) (
	input  logic                 clk,
	input  cell_ctl_t            ctl,
	input  logic [PRIO_W-1:0]    new_prio,
	input  logic [TAG_WIDTH-1:0] new_tag,
	input  logic [PRIO_W-1:0]    left_prio,
	input  logic [TAG_WIDTH-1:0] left_tag,
	input  logic [PRIO_W-1:0]    right_prio,
	input  logic [TAG_WIDTH-1:0] right_tag,
	output logic                 greater,
	output logic [PRIO_W-1:0]    prio,
	output logic [TAG_WIDTH-1:0] tag
);

	logic [PRIO_W-1:0]    prio_q;
	logic [TAG_WIDTH-1:0] tag_q;

	assign greater = prio_q > new_prio;
	assign prio    = prio_q;
	assign tag     = tag_q;

	always_ff @(posedge clk) begin
		priority if (ctl.load) begin
			prio_q <= new_prio;
			tag_q  <= new_tag;
		end else if (ctl.from_left) begin
			prio_q <= left_prio;
			tag_q  <= left_tag;
		end else if (ctl.from_right) begin
			prio_q <= right_prio;
			tag_q  <= right_tag;
		end else begin
			prio_q <= prio_q;
			tag_q  <= tag_q;
		end
	end

endmodule

// File: test/stable_priority_message_queue_unit_test.sv
`timescale 1ns / 100ps

module stable_priority_message_queue_unit_test;
	import spmq_pkg::*;

	localparam int unsigned QUEUE_DEPTH = 16;
	localparam int unsigned TAG_WIDTH   = 16;
	localparam int unsigned CYCLE_LIMIT = 200000;
	localparam logic [OP_W-1:0] OP_NOP = 2'd3;
	localparam logic [TAG_IO_W-1:0] TAG_MASK = TAG_IO_W'((64'd1 << TAG_WIDTH) - 64'd1);

	logic      clk = 1'b0;
	logic      arst_n;
	logic      req_valid;
	logic      req_stall;
	req_word_t req_word;
	logic      rsp_valid;
	logic      rsp_stall = 1'b0;
	rsp_word_t rsp_word;

	// Our own copy of the queue contents, in service order.
	logic [PRIO_W-1:0]   held_prio [QUEUE_DEPTH];
	logic [TAG_IO_W-1:0] held_tag  [QUEUE_DEPTH];
	int unsigned         held_count;

	rsp_word_t   expected_rsp [$];
	rsp_word_t   oldest_rsp;
	int unsigned errors = 0;
	int unsigned cycles = 0;
	int unsigned stall_left = 0;
	bit          quiet = 1'b0;

	stable_priority_message_queue_unit #(
		.QUEUE_DEPTH(QUEUE_DEPTH),
		.TAG_WIDTH  (TAG_WIDTH)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req_word (req_word),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp_word (rsp_word)
	);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("[stable_priority_message_queue_unit] ERROR");
			$finish;
		end
	end

	// Receiver back-pressure comes in random bursts.
	always @(posedge clk) begin
		if (stall_left > 0) begin
			rsp_stall <= 1'b1;
			stall_left <= stall_left - 1;
		end else if (!quiet && $urandom_range(0, 5) == 0) begin
			rsp_stall <= 1'b1;
			stall_left <= $urandom_range(0, 11);
		end else begin
			rsp_stall <= 1'b0;
		end
	end

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("%0t: %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
		errors++;
	endtask

	function automatic rsp_word_t predict_queue_op(input req_word_t w);
		rsp_word_t   r;
		int unsigned pos;
		r = '0;
		r.status = ST_OK;
		case (w.op)
			OP_WRITE: begin
				if (held_count >= QUEUE_DEPTH) begin
					r.status = ST_FULL;
				end else begin
					pos = held_count;
					// Insert ahead of the first strictly greater priority so ties keep order.
					if (w.ordered) begin
						for (int k = 0; k < held_count; k++)
							if (pos == held_count && held_prio[k] > w.priority_req)
								pos = k;
					end
					for (int k = held_count; k > pos; k--) begin
						held_prio[k] = held_prio[k - 1];
						held_tag[k]  = held_tag[k - 1];
					end
					held_prio[pos] = w.priority_req;
					held_tag[pos]  = w.tag & TAG_MASK;
					held_count++;
				end
			end
			OP_READ: begin
				if (held_count == 0) begin
					r.status = ST_EMPTY;
				end else begin
					r.head_tag      = held_tag[0];
					r.head_priority = held_prio[0];
					for (int k = 1; k < held_count; k++) begin
						held_prio[k - 1] = held_prio[k];
						held_tag[k - 1]  = held_tag[k];
					end
					held_count--;
				end
			end
			OP_CLEAR: held_count = 0;
			default: ;
		endcase
		r.occupancy = OCC_W'(held_count);
		return r;
	endfunction

	// Called right after a rising edge; returns right after the edge that took the word.
	task automatic send_word(input logic [OP_W-1:0] op, input logic ordered,
			input logic [PRIO_W-1:0] prio, input logic [TAG_IO_W-1:0] tag);
		req_word_t w;
		w.op = op;
		w.ordered = ordered;
		w.priority_req = prio;
		w.tag = tag;
		if (!quiet && $urandom_range(0, 4) == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
		req_valid <= 1'b1;
		req_word <= w;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		expected_rsp.push_back(predict_queue_op(w));
	endtask

	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (expected_rsp.size() == 0) begin
				report_mismatch("response word with nothing pending", 64'(rsp_word), 64'd0);
			end else begin
				oldest_rsp = expected_rsp.pop_front();
				if (rsp_word.status !== oldest_rsp.status)
					report_mismatch("status", 64'(rsp_word.status), 64'(oldest_rsp.status));
				if (rsp_word.head_tag !== oldest_rsp.head_tag)
					report_mismatch("head_tag", 64'(rsp_word.head_tag),
						64'(oldest_rsp.head_tag));
				if (rsp_word.head_priority !== oldest_rsp.head_priority)
					report_mismatch("head_priority", 64'(rsp_word.head_priority),
						64'(oldest_rsp.head_priority));
				if (rsp_word.occupancy !== oldest_rsp.occupancy)
					report_mismatch("occupancy", 64'(rsp_word.occupancy),
						64'(oldest_rsp.occupancy));
			end
		end
	end

	task automatic test_special_cases();
		send_word(OP_READ, 1'b1, 8'hFF, 16'hFFFF);
		send_word(OP_NOP, 1'b1, 8'hFF, 16'hFFFF);
		send_word(OP_CLEAR, 1'b1, 8'hFF, 16'hFFFF);
		send_word(OP_WRITE, 1'b0, 8'hFF, 16'hFFFF);
		send_word(OP_WRITE, 1'b0, 8'h00, 16'h0000);
		// Both zero-priority inserts land ahead of 0xFF but after each other.
		send_word(OP_WRITE, 1'b1, 8'h00, 16'h0001);
		send_word(OP_WRITE, 1'b1, 8'h00, 16'h0002);
		send_word(OP_WRITE, 1'b1, 8'hFF, 16'h0003);
		send_word(OP_NOP, 1'b0, 8'h5A, 16'h5A5A);
		repeat (5) send_word(OP_READ, 1'b1, 8'hA5, 16'hA5A5);
		send_word(OP_READ, 1'b0, 8'h00, 16'h0000);
		send_word(OP_WRITE, 1'b1, 8'h80, 16'hA5A5);
		send_word(OP_WRITE, 1'b1, 8'h7F, 16'h5A5A);
		send_word(OP_CLEAR, 1'b0, 8'h00, 16'h0000);
		send_word(OP_READ, 1'b0, 8'h00, 16'h0000);
	endtask

	task automatic test_fill_and_drain();
		for (int k = 0; k < QUEUE_DEPTH; k++)
			send_word(OP_WRITE, k[0], 8'(255 - 16 * k), 16'(16'h1111 * k));
		send_word(OP_WRITE, 1'b1, 8'h00, 16'hBEEF);
		send_word(OP_WRITE, 1'b0, 8'hFF, 16'hCAFE);
		send_word(OP_NOP, 1'b0, 8'h00, 16'h0000);
		repeat (QUEUE_DEPTH + 1) send_word(OP_READ, 1'b0, 8'h00, 16'h0000);
	endtask

	// Runs in segments that lean toward filling, toward draining or stay balanced, so
	// the queue swings between empty and full; narrow priorities make many ties.
	task automatic test_random_traffic(input int unsigned count);
		int unsigned sent;
		int unsigned seg_len;
		int unsigned write_pct;
		int unsigned roll;
		bit          narrow;
		logic [OP_W-1:0]   op;
		logic [PRIO_W-1:0] prio;
		sent = 0;
		while (sent < count) begin
			seg_len = $urandom_range(20, 60);
			case ($urandom_range(0, 2))
				0: write_pct = 75;
				1: write_pct = 30;
				default: write_pct = 50;
			endcase
			narrow = $urandom_range(0, 1);
			for (int i = 0; i < seg_len && sent < count; i++) begin
				roll = $urandom_range(0, 99);
				if (roll < 2)
					op = OP_NOP;
				else if (roll < 5)
					op = OP_CLEAR;
				else if (roll < 5 + write_pct)
					op = OP_WRITE;
				else
					op = OP_READ;
				prio = narrow ? 8'($urandom_range(0, 3) * 85) : 8'($urandom_range(0, 255));
				send_word(op, 1'($urandom_range(0, 1)), prio, 16'($urandom_range(0, 65535)));
				sent++;
			end
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		req_valid <= 1'b0;
		req_word <= '0;
		held_count = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_special_cases();
		test_fill_and_drain();
		test_random_traffic(600);
		quiet = 1'b1;
		test_random_traffic(150);

		req_valid <= 1'b0;
		while (expected_rsp.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		if (errors == 0)
			$display("[stable_priority_message_queue_unit] OK");
		else
			$display("[stable_priority_message_queue_unit] ERROR");
		$finish;
	end

endmodule
